>>> design/lpch_pkg.sv
package lpch_pkg;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_HEIGHT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MM_PER_TICK = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAR         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_OFFSET = 3'd5;

    // Register values after reset.
    localparam logic [11:0] RST_MAX_HEIGHT  = 12'd800;
    localparam logic [15:0] RST_MM_PER_TICK = 16'd2689;
    localparam logic [7:0]  RST_DEADBAND    = 8'd8;
    localparam logic [7:0]  RST_NEAR        = 8'd15;
    localparam logic [7:0]  RST_FAR         = 8'd30;
    localparam logic [7:0]  RST_HOME_OFFSET = 8'd15;

    // Speed commands.
    localparam logic signed [6:0] RPM_STOP = 7'sd0;
    localparam logic signed [6:0] RPM_SLOW = 7'sd12;
    localparam logic signed [6:0] RPM_MID  = 7'sd25;
    localparam logic signed [6:0] RPM_FAST = 7'sd40;
    localparam logic signed [6:0] RPM_HOME = 7'sd15;
    localparam logic signed [6:0] RPM_SEEK = -7'sd15;

    // Encoder jumps of this many counts or more are discarded.
    localparam logic signed [31:0] ENC_JUMP_LIMIT = 32'sd1000;

    typedef enum logic [1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_MOVE      = 2'd1,
        FUNC_CALIBRATE = 2'd2,
        FUNC_LIMIT     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SEEK   = 2'd1,
        MODE_HOME   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [11:0] max_height_mm;
        logic [15:0] mm_per_tick;
        logic [7:0]  deadband_mm;
        logic [7:0]  near_mm;
        logic [7:0]  far_mm;
        logic [7:0]  home_offset_mm;
    } cfg_t;

    typedef struct packed {
        func_t              func;
        logic [19:0]        target_pos;
        logic signed [31:0] encoder_count;
        logic [2:0]         motor_index;
    } item_t;

    typedef struct packed {
        logic signed [6:0]  motor_rpm;
        logic               rpm_issued;
        logic               encoder_reset;
        logic signed [31:0] position;
        logic               target_active;
        mode_t              mode;
    } result_t;

endpackage

>>> design/lpch_cfg.sv
module lpch_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lpch_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lpch_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output lpch_pkg::cfg_t                   cfg
);

    lpch_pkg::cfg_t cfg_reg;
    lpch_pkg::cfg_t cfg_next;

    // Each register keeps its own low bits of the write data.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                lpch_pkg::CFG_MAX_HEIGHT:  cfg_next.max_height_mm  = cfg_wdata[11:0];
                lpch_pkg::CFG_MM_PER_TICK: cfg_next.mm_per_tick    = cfg_wdata[15:0];
                lpch_pkg::CFG_DEADBAND:    cfg_next.deadband_mm    = cfg_wdata[7:0];
                lpch_pkg::CFG_NEAR:        cfg_next.near_mm        = cfg_wdata[7:0];
                lpch_pkg::CFG_FAR:         cfg_next.far_mm         = cfg_wdata[7:0];
                lpch_pkg::CFG_HOME_OFFSET: cfg_next.home_offset_mm = cfg_wdata[7:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_height_mm  <= lpch_pkg::RST_MAX_HEIGHT;
            cfg_reg.mm_per_tick    <= lpch_pkg::RST_MM_PER_TICK;
            cfg_reg.deadband_mm    <= lpch_pkg::RST_DEADBAND;
            cfg_reg.near_mm        <= lpch_pkg::RST_NEAR;
            cfg_reg.far_mm         <= lpch_pkg::RST_FAR;
            cfg_reg.home_offset_mm <= lpch_pkg::RST_HOME_OFFSET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/lpch_ctrl.sv
module lpch_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  lpch_pkg::item_t    item,
    input  lpch_pkg::cfg_t     cfg,
    output lpch_pkg::result_t  result
);

    logic signed [31:0] position_reg,     position_next;
    logic [19:0]        target_q8_reg,    target_q8_next;
    logic               target_valid_reg, target_valid_next;
    logic signed [6:0]  last_speed_reg,   last_speed_next;
    logic signed [31:0] last_encoder_reg, last_encoder_next;
    lpch_pkg::mode_t    mode_reg,         mode_next;

    // Speed selection from the distance still to go.
    logic signed [33:0] err;
    logic [32:0]        distance;
    logic               in_deadband;
    logic               above_far;
    logic               above_near;
    logic signed [6:0]  speed_mag;
    logic signed [6:0]  speed;

    // Encoder integration.
    logic signed [31:0] delta;
    logic               delta_ok;
    logic signed [10:0] delta_s;
    logic signed [16:0] step_s;
    logic signed [27:0] prod;
    logic signed [32:0] sum;
    logic signed [31:0] sum_sat;
    logic signed [31:0] pos_tick;
    logic               home_reached;

    logic [19:0]        move_limit;

    always_comb begin
        err  = $signed({6'b0, target_q8_reg, 8'b0})
             - $signed({{2{position_reg[31]}}, position_reg});
        distance    = err[33] ? 33'(-err) : err[32:0];
        in_deadband = distance <= {9'b0, cfg.deadband_mm, 16'b0};
        above_far   = distance > {9'b0, cfg.far_mm, 16'b0};
        above_near  = distance > {9'b0, cfg.near_mm, 16'b0};
        priority if (above_far) begin
            speed_mag = lpch_pkg::RPM_FAST;
        end else if (above_near) begin
            speed_mag = lpch_pkg::RPM_MID;
        end else begin
            speed_mag = lpch_pkg::RPM_SLOW;
        end
        if (!target_valid_reg || in_deadband) begin
            speed = lpch_pkg::RPM_STOP;
        end else if (err[33]) begin
            speed = -speed_mag;
        end else begin
            speed = speed_mag;
        end
    end

    always_comb begin
        delta    = item.encoder_count - last_encoder_reg;
        delta_ok = (delta > -lpch_pkg::ENC_JUMP_LIMIT) && (delta < lpch_pkg::ENC_JUMP_LIMIT);
        delta_s  = delta[10:0];
        step_s   = $signed({1'b0, cfg.mm_per_tick});
        prod     = delta_s * step_s;
        sum      = $signed({position_reg[31], position_reg})
                 + $signed({{5{prod[27]}}, prod});
        if (sum[32] != sum[31]) begin
            sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sum_sat = sum[31:0];
        end
        pos_tick     = delta_ok ? sum_sat : position_reg;
        home_reached = pos_tick >= $signed({8'b0, cfg.home_offset_mm, 16'b0});
        move_limit   = {cfg.max_height_mm, 8'b0};
    end

    always_comb begin
        position_next     = position_reg;
        target_q8_next    = target_q8_reg;
        target_valid_next = target_valid_reg;
        last_speed_next   = last_speed_reg;
        last_encoder_next = last_encoder_reg;
        mode_next         = mode_reg;

        result.motor_rpm     = lpch_pkg::RPM_STOP;
        result.rpm_issued    = 1'b0;
        result.encoder_reset = 1'b0;

        unique case (item.func)
            lpch_pkg::FUNC_TICK: begin
                if (target_valid_reg && in_deadband) begin
                    target_valid_next = 1'b0;
                end
                if (mode_reg == lpch_pkg::MODE_NORMAL && speed != last_speed_reg) begin
                    result.motor_rpm  = speed;
                    result.rpm_issued = 1'b1;
                    last_speed_next   = speed;
                end
                position_next = pos_tick;
                if (delta_ok) begin
                    last_encoder_next = item.encoder_count;
                end
                if (mode_reg == lpch_pkg::MODE_HOME) begin
                    result.rpm_issued = 1'b1;
                    if (home_reached) begin
                        result.motor_rpm = lpch_pkg::RPM_STOP;
                        mode_next        = lpch_pkg::MODE_NORMAL;
                    end else begin
                        result.motor_rpm = lpch_pkg::RPM_HOME;
                    end
                end
            end
            lpch_pkg::FUNC_MOVE: begin
                target_q8_next    = (item.target_pos > move_limit) ? move_limit
                                                                   : item.target_pos;
                target_valid_next = 1'b1;
            end
            lpch_pkg::FUNC_CALIBRATE: begin
                target_valid_next = 1'b0;
                result.motor_rpm  = lpch_pkg::RPM_SEEK;
                result.rpm_issued = 1'b1;
                mode_next         = lpch_pkg::MODE_SEEK;
            end
            lpch_pkg::FUNC_LIMIT: begin
                if (mode_reg == lpch_pkg::MODE_SEEK && item.motor_index == 3'd0) begin
                    position_next        = '0;
                    last_encoder_next    = '0;
                    result.encoder_reset = 1'b1;
                    result.motor_rpm     = lpch_pkg::RPM_HOME;
                    result.rpm_issued    = 1'b1;
                    mode_next            = lpch_pkg::MODE_HOME;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase

        result.position      = position_next;
        result.target_active = target_valid_next;
        result.mode          = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg     <= '0;
            target_q8_reg    <= '0;
            target_valid_reg <= 1'b0;
            last_speed_reg   <= '0;
            last_encoder_reg <= '0;
            mode_reg         <= lpch_pkg::MODE_NORMAL;
        end else if (step) begin
            position_reg     <= position_next;
            target_q8_reg    <= target_q8_next;
            target_valid_reg <= target_valid_next;
            last_speed_reg   <= last_speed_next;
            last_encoder_reg <= last_encoder_next;
            mode_reg         <= mode_next;
        end
    end

endmodule

>>> design/lift_position_controller_homing_unit.sv
// Channel   | Dir | Handshake           | Payload
// ----------+-----+---------------------+---------------------------------------------
// request   | in  | s_tvalid / s_tready | s_tuser func, s_tdata target/encoder/motor
// result    | out | m_tvalid / m_tready | m_tdata rpm, flags, position, mode
// config    | in  | cfg_wr_en           | cfg_addr register index, cfg_wdata value
//
// Each request yields one result; the request waits in the input register until the
// result register can take it; one request per cycle is accepted while the result side keeps up.
// Reset is synchronous and active low; it restores the register defaults and clears
// the position, target, encoder and homing state.
// A stalled result holds its register; the request side stalls in the same cycle
// only when both the input register and the result register are full.
module lift_position_controller_homing_unit (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [19:0] target_pos, [51:20] encoder_count, [54:52] motor_index, [55] unused
    input  logic [55:0]                      s_tdata,
    // [1:0] func
    input  logic [1:0]                       s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] motor_rpm, [7] rpm_issued, [8] encoder_reset, [40:9] position,
    // [41] target_active, [43:42] mode, [47:44] zero
    output logic [47:0]                      m_tdata,

    input  logic                             cfg_wr_en,
    input  logic [lpch_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lpch_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    lpch_pkg::cfg_t    cfg;
    lpch_pkg::item_t   in_item;
    lpch_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    lpch_pkg::result_t result;
    lpch_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              step;

    // The result register can take a new value when it is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_item.func          = lpch_pkg::func_t'(s_tuser);
        in_item.target_pos    = s_tdata[19:0];
        in_item.encoder_count = $signed(s_tdata[51:20]);
        in_item.motor_index   = s_tdata[54:52];
    end

    lpch_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The controller state advances exactly when the registered request moves
    // into the result register, so back-to-back requests see each other's updates.
    lpch_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.mode, out_reg.target_active, out_reg.position,
                       out_reg.encoder_reset, out_reg.rpm_issued, out_reg.motor_rpm};

endmodule

>>> design/lpch_checker.sv
module lpch_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A nonzero speed is only ever shown as a fresh command.
    a_rpm_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6:0] != 7'd0 |-> m_tdata[7])
        else $error("nonzero rpm without issue flag");

    // An encoder reset comes only from the limit switch: position zero, drive up
    // at homing speed, and the axis is in the drive-to-offset phase.
    a_enc_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |->
            m_tdata[40:9] == 32'd0 && m_tdata[7]
            && m_tdata[6:0] == lpch_pkg::RPM_HOME
            && m_tdata[43:42] == lpch_pkg::MODE_HOME)
        else $error("encoder reset with inconsistent result");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lift_position_controller_homing_unit lpch_checker u_lpch_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
